FILE: hw/rtl/ptg_pkg.sv
// Shared constants, types and register codes of the pixel-to-ground mapper.
package ptg_pkg;

  localparam int PIXEL_FRAC_BITS = 4;
  localparam int GROUND_WIDTH    = 20;
  localparam int INVF_BITS       = 24;
  localparam int PIX_W           = 16;
  localparam int ROT_W           = 16;
  localparam int ROT_FRAC        = 14;
  localparam int TRN_W           = 20;
  localparam int TRN_FRAC        = 14;
  localparam int ROT_ROW_W       = 3 * ROT_W;
  localparam int TRN_VEC_W       = 3 * TRN_W;
  localparam int PP_W            = 2 * PIX_W;
  localparam int IFOC_W          = 2 * INVF_BITS;
  localparam int CFG_W           = TRN_VEC_W;
  localparam int CFG_IDX_W       = 3;

  // ray direction carries PIXEL_FRAC_BITS + INVF_BITS fraction bits
  localparam int DIR_FRAC  = PIXEL_FRAC_BITS + INVF_BITS;
  localparam int D_W       = PIX_W + 1 + INVF_BITS + 1;
  localparam int RT_W      = ROT_W + TRN_W;
  localparam int RD_W      = ROT_W + D_W;
  localparam int NUM_W     = RT_W + 2;
  localparam int DEN_W     = RD_W + 2;
  localparam int SPLIT_W   = DEN_W / 2;
  localparam int PROD_W    = NUM_W + DEN_W;
  localparam int QUOT_BITS = 62;
  localparam int SQ_W      = QUOT_BITS + 2;
  localparam int T_W       = SQ_W + 1;
  localparam int GROUND_FRAC = 12;
  localparam int ROUND_SHIFT = ROT_FRAC + TRN_FRAC - GROUND_FRAC;
  localparam int RR_W      = T_W - ROUND_SHIFT;

  // magnitude, product, sum, remainder setup, divide steps, sign, subtract, round
  localparam int LANE_LAT  = 4 + QUOT_BITS + 3;

  localparam int MQ_DEPTH  = 4;
  localparam int MQ_PTR_W  = $clog2(MQ_DEPTH);
  localparam int OQ_DEPTH  = 2;
  localparam int OQ_PTR_W  = $clog2(OQ_DEPTH);

  localparam logic [ROT_ROW_W-1:0] ROT0_RST = ROT_ROW_W'(48'd16384);
  localparam logic [ROT_ROW_W-1:0] ROT1_RST = ROT_ROW_W'(48'd1073741824);
  localparam logic [ROT_ROW_W-1:0] ROT2_RST = ROT_ROW_W'(48'd70368744177664);
  localparam logic [TRN_VEC_W-1:0] TRN_RST  = '0;
  localparam logic [PP_W-1:0]      PP_RST   = PP_W'(32'd251663360);
  localparam logic [IFOC_W-1:0]    IFOC_RST = IFOC_W'(48'd562942739218);

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_ROT0 = 3'd0,
    REG_ROT1 = 3'd1,
    REG_ROT2 = 3'd2,
    REG_TRN  = 3'd3,
    REG_PP   = 3'd4,
    REG_IFOC = 3'd5
  } cfg_idx_e;

  typedef enum logic [1:0] {
    ST_HIT      = 2'd0,
    ST_PARALLEL = 2'd1,
    ST_BEHIND   = 2'd2
  } status_e;

  typedef struct packed {
    status_e                  status;
    logic signed [NUM_W-1:0]  num;
    logic signed [DEN_W-1:0]  den;
    logic signed [DEN_W-1:0]  a0;
    logic signed [DEN_W-1:0]  a1;
    logic signed [NUM_W-1:0]  b0;
    logic signed [NUM_W-1:0]  b1;
  } ray_item_t;

  typedef struct packed {
    status_e                        status;
    logic signed [GROUND_WIDTH-1:0] x;
    logic signed [GROUND_WIDTH-1:0] y;
  } result_t;

endpackage

FILE: hw/rtl/pixel_to_ground_ipm_core.sv
// Top level of the pixel-to-ground inverse perspective mapper.
// Maps an image pixel (u,v), unsigned Q12.4, onto the rig ground plane z=0 and
// returns a hit status plus ground x and y in signed Q8.12, saturated.
// Input side is a queue write port: an item is taken on a clock edge with push
// high and full low. Result side is a queue read port: the oldest result sits
// on the result ports while empty is low and leaves on an edge with pop high.
// Configuration registers are written through cfg_we_i/cfg_idx_i/cfg_data_i;
// the user must write them only while no items are in flight, which the block
// itself does not enforce. Unknown indexes are ignored. From accept to empty
// going low an item passes 3 front stages, 1 middle-queue write, LANE_LAT = 69
// back stages (magnitude, split product, sum, 62 one-bit divide steps, sign,
// subtract, round/saturate) and 1 result-queue write: 74 register stages.
// Throughput is one pixel per clock while full is low; the 62-step restoring
// divide is fully pipelined, one step per stage, with one divider lane per
// ground axis. When the receiver stalls, a 2-entry result queue fills, the
// back pipeline holds, then the 4-entry middle queue fills and full rises.
// Reset clears all queues and valid bits and loads the identity pose, zero
// translation, principal point (320,240) and focal 500 in both axes.
module pixel_to_ground_ipm_core (
  input  logic                                    clk_i,
  input  logic                                    rst_ni,
  input  logic                                    cfg_we_i,
  input  logic [ptg_pkg::CFG_IDX_W-1:0]           cfg_idx_i,
  input  logic [ptg_pkg::CFG_W-1:0]               cfg_data_i,
  input  logic                                    push,
  output logic                                    full,
  input  logic [ptg_pkg::PIX_W-1:0]               pixel_u_i,
  input  logic [ptg_pkg::PIX_W-1:0]               pixel_v_i,
  output logic                                    empty,
  input  logic                                    pop,
  output logic [1:0]                              hit_status_o,
  output logic signed [ptg_pkg::GROUND_WIDTH-1:0] ground_x_o,
  output logic signed [ptg_pkg::GROUND_WIDTH-1:0] ground_y_o
);
  import ptg_pkg::*;

  logic      fr_valid, mq_full, mq_empty, mq_pop;
  ray_item_t fr_item, mq_item;
  result_t   res;

  ptg_front u_front (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_we_i     (cfg_we_i),
    .cfg_idx_i    (cfg_idx_i),
    .cfg_data_i   (cfg_data_i),
    .push_i       (push),
    .full_o       (full),
    .pixel_u_i    (pixel_u_i),
    .pixel_v_i    (pixel_v_i),
    .item_valid_o (fr_valid),
    .item_o       (fr_item),
    .queue_full_i (mq_full)
  );

  ptg_mid_queue u_mid_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (fr_valid),
    .item_i  (fr_item),
    .full_o  (mq_full),
    .pop_i   (mq_pop),
    .empty_o (mq_empty),
    .item_o  (mq_item)
  );

  ptg_back u_back (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .mq_empty_i (mq_empty),
    .mq_item_i  (mq_item),
    .mq_pop_o   (mq_pop),
    .empty_o    (empty),
    .pop_i      (pop),
    .result_o   (res)
  );

  assign hit_status_o = res.status;
  assign ground_x_o   = res.x;
  assign ground_y_o   = res.y;

endmodule

FILE: hw/rtl/ptg_front.sv
// Front end: configuration registers, ray setup and hit classification.
module ptg_front (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            cfg_we_i,
  input  logic [ptg_pkg::CFG_IDX_W-1:0]   cfg_idx_i,
  input  logic [ptg_pkg::CFG_W-1:0]       cfg_data_i,
  input  logic                            push_i,
  output logic                            full_o,
  input  logic [ptg_pkg::PIX_W-1:0]       pixel_u_i,
  input  logic [ptg_pkg::PIX_W-1:0]       pixel_v_i,
  output logic                            item_valid_o,
  output ptg_pkg::ray_item_t              item_o,
  input  logic                            queue_full_i
);
  import ptg_pkg::*;

  logic [ROT_ROW_W-1:0] rot_q [3];
  logic [TRN_VEC_W-1:0] trn_q;
  logic [PP_W-1:0]      pp_q;
  logic [IFOC_W-1:0]    ifoc_q;

  logic signed [ROT_W-1:0] rm [3][3];
  logic signed [TRN_W-1:0] tv [3];

  logic en;
  logic v1_q, v2_q, v3_q;

  logic signed [PIX_W:0]   du, dv;
  logic signed [D_W-1:0]   d0_d, d1_d, d0_q, d1_q;
  logic signed [RT_W-1:0]  rt_q [3][3];
  logic signed [RD_W-1:0]  rd_q [2][3];
  logic signed [NUM_W-1:0] num2_q, b0_2_q, b1_2_q;
  logic signed [DEN_W-1:0] den_d, a0_d, a1_d;
  status_e                 st_d;
  ray_item_t               item_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rot_q[0] <= ROT0_RST;
      rot_q[1] <= ROT1_RST;
      rot_q[2] <= ROT2_RST;
      trn_q    <= TRN_RST;
      pp_q     <= PP_RST;
      ifoc_q   <= IFOC_RST;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        REG_ROT0: rot_q[0] <= cfg_data_i[ROT_ROW_W-1:0];
        REG_ROT1: rot_q[1] <= cfg_data_i[ROT_ROW_W-1:0];
        REG_ROT2: rot_q[2] <= cfg_data_i[ROT_ROW_W-1:0];
        REG_TRN:  trn_q    <= cfg_data_i[TRN_VEC_W-1:0];
        REG_PP:   pp_q     <= cfg_data_i[PP_W-1:0];
        REG_IFOC: ifoc_q   <= cfg_data_i[IFOC_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    for (int k = 0; k < 3; k++) begin
      tv[k] = trn_q[TRN_W*k +: TRN_W];
      for (int j = 0; j < 3; j++) begin
        rm[k][j] = rot_q[k][ROT_W*j +: ROT_W];
      end
    end
  end

  assign en           = !queue_full_i;
  assign full_o       = queue_full_i;
  assign item_valid_o = v3_q;
  assign item_o       = item_q;

  assign du   = $signed({1'b0, pixel_u_i}) - $signed({1'b0, pp_q[PIX_W-1:0]});
  assign dv   = $signed({1'b0, pixel_v_i}) - $signed({1'b0, pp_q[PP_W-1:PIX_W]});
  assign d0_d = D_W'(du) * D_W'($signed({1'b0, ifoc_q[INVF_BITS-1:0]}));
  assign d1_d = D_W'(dv) * D_W'($signed({1'b0, ifoc_q[IFOC_W-1:INVF_BITS]}));

  // third ray component is exactly one, so its terms are plain shifts
  assign den_d = DEN_W'(rd_q[0][2]) + DEN_W'(rd_q[1][2]) + (DEN_W'(rm[2][2]) <<< DIR_FRAC);
  assign a0_d  = DEN_W'(rd_q[0][0]) + DEN_W'(rd_q[1][0]) + (DEN_W'(rm[2][0]) <<< DIR_FRAC);
  assign a1_d  = DEN_W'(rd_q[0][1]) + DEN_W'(rd_q[1][1]) + (DEN_W'(rm[2][1]) <<< DIR_FRAC);

  always_comb begin
    priority if (den_d == '0) begin
      st_d = ST_PARALLEL;
    end else if (num2_q == '0 || ((num2_q < 0) != (den_d < 0))) begin
      st_d = ST_BEHIND;
    end else begin
      st_d = ST_HIT;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
      v2_q <= 1'b0;
      v3_q <= 1'b0;
    end else if (en) begin
      v1_q <= push_i;
      v2_q <= v1_q;
      v3_q <= v2_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      d0_q <= d0_d;
      d1_q <= d1_d;
      for (int k = 0; k < 3; k++) begin
        for (int j = 0; j < 3; j++) begin
          rt_q[k][j] <= RT_W'(rm[k][j]) * RT_W'(tv[k]);
        end
      end
      for (int j = 0; j < 3; j++) begin
        rd_q[0][j] <= RD_W'(rm[0][j]) * RD_W'(d0_q);
        rd_q[1][j] <= RD_W'(rm[1][j]) * RD_W'(d1_q);
      end
      num2_q <= NUM_W'(rt_q[0][2]) + NUM_W'(rt_q[1][2]) + NUM_W'(rt_q[2][2]);
      b0_2_q <= NUM_W'(rt_q[0][0]) + NUM_W'(rt_q[1][0]) + NUM_W'(rt_q[2][0]);
      b1_2_q <= NUM_W'(rt_q[0][1]) + NUM_W'(rt_q[1][1]) + NUM_W'(rt_q[2][1]);
      item_q.status <= st_d;
      item_q.num    <= num2_q;
      item_q.den    <= den_d;
      item_q.a0     <= a0_d;
      item_q.a1     <= a1_d;
      item_q.b0     <= b0_2_q;
      item_q.b1     <= b1_2_q;
    end
  end

endmodule

FILE: hw/rtl/ptg_mid_queue.sv
// Short queue of classified rays between the front end and the divide back end.
module ptg_mid_queue (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               push_i,
  input  ptg_pkg::ray_item_t item_i,
  output logic               full_o,
  input  logic               pop_i,
  output logic               empty_o,
  output ptg_pkg::ray_item_t item_o
);
  import ptg_pkg::*;

  ray_item_t           mem_q [MQ_DEPTH];
  logic [MQ_PTR_W-1:0] wr_q, rd_q;
  logic [MQ_PTR_W:0]   cnt_q;
  logic                do_push, do_pop;

  assign full_o  = (cnt_q == (MQ_PTR_W+1)'(MQ_DEPTH));
  assign empty_o = (cnt_q == '0);
  assign do_push = push_i && !full_o;
  assign do_pop  = pop_i && !empty_o;
  assign item_o  = mem_q[rd_q];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= '0;
      rd_q  <= '0;
      cnt_q <= '0;
    end else begin
      if (do_push) wr_q <= wr_q + 1'b1;
      if (do_pop)  rd_q <= rd_q + 1'b1;
      if (do_push && !do_pop) begin
        cnt_q <= cnt_q + 1'b1;
      end else if (do_pop && !do_push) begin
        cnt_q <= cnt_q - 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) mem_q[wr_q] <= item_i;
  end

endmodule

FILE: hw/rtl/ptg_div_lane.sv
// One ground axis: scaled product, restoring divide pipeline, round and saturate.
module ptg_div_lane (
  input  logic                                   clk_i,
  input  logic                                   en_i,
  input  logic signed [ptg_pkg::NUM_W-1:0]       num_i,
  input  logic signed [ptg_pkg::DEN_W-1:0]       den_i,
  input  logic signed [ptg_pkg::DEN_W-1:0]       a_i,
  input  logic signed [ptg_pkg::NUM_W-1:0]       b_i,
  output logic signed [ptg_pkg::GROUND_WIDTH-1:0] gnd_o
);
  import ptg_pkg::*;

  typedef struct packed {
    logic [DEN_W-1:0]         r;
    logic [QUOT_BITS-1:0]     low;
    logic [QUOT_BITS-1:0]     q;
    logic [DEN_W-1:0]         dm;
    logic                     neg;
    logic                     clamp;
    logic signed [NUM_W-1:0]  b;
  } div_stage_t;

  localparam logic signed [RR_W-1:0] GMAX = RR_W'((longint'(1) << (GROUND_WIDTH - 1)) - 1);
  localparam logic signed [RR_W-1:0] GMIN = -GMAX - RR_W'(1);

  // magnitudes
  logic [NUM_W-1:0]        nm_q;
  logic [DEN_W-1:0]        am_q, dm0_q, dm1_q, dm2_q;
  logic                    neg0_q, neg1_q, neg2_q;
  logic signed [NUM_W-1:0] b0_q, b1_q, b2_q;
  logic [NUM_W+SPLIT_W-1:0]         pl_q;
  logic [NUM_W+DEN_W-SPLIT_W-1:0]   ph_q;
  logic [PROD_W-1:0]       p_q;
  div_stage_t              stg_q [QUOT_BITS+1];

  logic [QUOT_BITS:0]      qm;
  logic signed [SQ_W-1:0]  sq_q;
  logic signed [NUM_W-1:0] be_q;
  logic signed [T_W-1:0]   t_q;
  logic signed [RR_W-1:0]  rr;
  logic signed [GROUND_WIDTH-1:0] gnd_q;

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      nm_q   <= (num_i < 0) ? NUM_W'(-num_i) : NUM_W'(num_i);
      am_q   <= (a_i < 0) ? DEN_W'(-a_i) : DEN_W'(a_i);
      dm0_q  <= (den_i < 0) ? DEN_W'(-den_i) : DEN_W'(den_i);
      neg0_q <= (num_i < 0) ^ (a_i < 0) ^ (den_i < 0);
      b0_q   <= b_i;

      pl_q   <= (NUM_W+SPLIT_W)'(nm_q) * (NUM_W+SPLIT_W)'(am_q[SPLIT_W-1:0]);
      ph_q   <= (NUM_W+DEN_W-SPLIT_W)'(nm_q) *
                (NUM_W+DEN_W-SPLIT_W)'(am_q[DEN_W-1:SPLIT_W]);
      dm1_q  <= dm0_q;
      neg1_q <= neg0_q;
      b1_q   <= b0_q;

      p_q    <= PROD_W'(pl_q) + (PROD_W'(ph_q) << SPLIT_W);
      dm2_q  <= dm1_q;
      neg2_q <= neg1_q;
      b2_q   <= b1_q;

      // quotient at or above the limit clamps; otherwise the top part seeds the remainder
      stg_q[0].clamp <= (p_q >> QUOT_BITS) >= PROD_W'(dm2_q);
      stg_q[0].r     <= DEN_W'(p_q >> QUOT_BITS);
      stg_q[0].low   <= p_q[QUOT_BITS-1:0];
      stg_q[0].q     <= '0;
      stg_q[0].dm    <= dm2_q;
      stg_q[0].neg   <= neg2_q;
      stg_q[0].b     <= b2_q;
    end
  end

  for (genvar s = 0; s < QUOT_BITS; s++) begin : g_div
    logic [DEN_W:0] rs;
    logic           ge;
    assign rs = {stg_q[s].r, stg_q[s].low[QUOT_BITS-1]};
    assign ge = rs >= {1'b0, stg_q[s].dm};
    always_ff @(posedge clk_i) begin
      if (en_i) begin
        stg_q[s+1].r     <= ge ? DEN_W'(rs - {1'b0, stg_q[s].dm}) : DEN_W'(rs);
        stg_q[s+1].low   <= stg_q[s].low << 1;
        stg_q[s+1].q     <= {stg_q[s].q[QUOT_BITS-2:0], ge};
        stg_q[s+1].dm    <= stg_q[s].dm;
        stg_q[s+1].neg   <= stg_q[s].neg;
        stg_q[s+1].clamp <= stg_q[s].clamp;
        stg_q[s+1].b     <= stg_q[s].b;
      end
    end
  end

  assign qm = stg_q[QUOT_BITS].clamp ? {1'b1, {QUOT_BITS{1'b0}}}
                                     : {1'b0, stg_q[QUOT_BITS].q};
  // floor((t + half) / 2^ROUND_SHIFT): round half toward plus infinity
  assign rr = RR_W'(t_q >>> ROUND_SHIFT);

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      sq_q <= stg_q[QUOT_BITS].neg ? -$signed(SQ_W'(qm)) : $signed(SQ_W'(qm));
      be_q <= stg_q[QUOT_BITS].b;
      t_q  <= T_W'(sq_q) - T_W'(be_q) + (T_W'(1) <<< (ROUND_SHIFT - 1));
      priority if (rr > GMAX) begin
        gnd_q <= GROUND_WIDTH'(GMAX);
      end else if (rr < GMIN) begin
        gnd_q <= GROUND_WIDTH'(GMIN);
      end else begin
        gnd_q <= GROUND_WIDTH'(rr);
      end
    end
  end

  assign gnd_o = gnd_q;

endmodule

FILE: hw/rtl/ptg_back.sv
// Back end: two divide lanes, status pipeline and the result queue.
module ptg_back (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               mq_empty_i,
  input  ptg_pkg::ray_item_t mq_item_i,
  output logic               mq_pop_o,
  output logic               empty_o,
  input  logic               pop_i,
  output ptg_pkg::result_t   result_o
);
  import ptg_pkg::*;

  logic                           en;
  logic [LANE_LAT-1:0]            vld_q;
  status_e                        st_q [LANE_LAT];
  logic signed [GROUND_WIDTH-1:0] gx, gy;

  result_t             oq_q [OQ_DEPTH];
  logic [OQ_PTR_W-1:0] oq_wr_q, oq_rd_q;
  logic [OQ_PTR_W:0]   oq_cnt_q;
  logic                oq_full, oq_push, oq_pop;
  result_t             res_d;

  assign oq_full  = (oq_cnt_q == (OQ_PTR_W+1)'(OQ_DEPTH));
  // hold the whole pipeline while the result queue is full
  assign en       = !oq_full;
  assign mq_pop_o = en && !mq_empty_i;

  ptg_div_lane u_lane_x (
    .clk_i (clk_i),
    .en_i  (en),
    .num_i (mq_item_i.num),
    .den_i (mq_item_i.den),
    .a_i   (mq_item_i.a0),
    .b_i   (mq_item_i.b0),
    .gnd_o (gx)
  );

  ptg_div_lane u_lane_y (
    .clk_i (clk_i),
    .en_i  (en),
    .num_i (mq_item_i.num),
    .den_i (mq_item_i.den),
    .a_i   (mq_item_i.a1),
    .b_i   (mq_item_i.b1),
    .gnd_o (gy)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else if (en) begin
      vld_q <= {vld_q[LANE_LAT-2:0], !mq_empty_i};
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      st_q[0] <= mq_item_i.status;
      for (int i = 1; i < LANE_LAT; i++) begin
        st_q[i] <= st_q[i-1];
      end
    end
  end

  // drop the coordinates of a miss
  always_comb begin
    res_d.status = st_q[LANE_LAT-1];
    res_d.x      = (st_q[LANE_LAT-1] == ST_HIT) ? gx : '0;
    res_d.y      = (st_q[LANE_LAT-1] == ST_HIT) ? gy : '0;
  end

  assign oq_push  = en && vld_q[LANE_LAT-1];
  assign oq_pop   = pop_i && !empty_o;
  assign empty_o  = (oq_cnt_q == '0);
  assign result_o = oq_q[oq_rd_q];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      oq_wr_q  <= '0;
      oq_rd_q  <= '0;
      oq_cnt_q <= '0;
    end else begin
      if (oq_push) oq_wr_q <= oq_wr_q + 1'b1;
      if (oq_pop)  oq_rd_q <= oq_rd_q + 1'b1;
      if (oq_push && !oq_pop) begin
        oq_cnt_q <= oq_cnt_q + 1'b1;
      end else if (oq_pop && !oq_push) begin
        oq_cnt_q <= oq_cnt_q - 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (oq_push) oq_q[oq_wr_q] <= res_d;
  end

  a_miss_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (!empty_o && result_o.status != ST_HIT) |-> (result_o.x == '0 && result_o.y == '0))
    else $error("non-hit result carries nonzero coordinates");

  a_stall_holds: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !en |=> $stable(vld_q))
    else $error("pipeline moved while result queue full");

  a_oq_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    oq_cnt_q <= (OQ_PTR_W+1)'(OQ_DEPTH))
    else $error("result queue overflow");

endmodule

FILE: sim/pixel_to_ground_ipm_core_tb.sv
// Self-checking testbench of the pixel-to-ground mapper: queued requests, predicted results.
module pixel_to_ground_ipm_core_tb;
  timeunit 1ns;
  timeprecision 1ps;
  import ptg_pkg::*;

  localparam logic [CFG_IDX_W-1:0] REG_SPARE6 = 3'd6;
  localparam logic [CFG_IDX_W-1:0] REG_SPARE7 = 3'd7;
  localparam int SETTLE = 120;
  localparam int CYCLE_LIMIT = 400000;

  typedef struct {
    logic [PIX_W-1:0] u;
    logic [PIX_W-1:0] v;
  } pixel_t;

  logic clk_i, rst_ni;
  logic cfg_we_i;
  logic [CFG_IDX_W-1:0] cfg_idx_i;
  logic [CFG_W-1:0] cfg_data_i;
  logic push, full, empty, pop;
  logic [PIX_W-1:0] pixel_u_i, pixel_v_i;
  logic [1:0] hit_status_o;
  logic signed [GROUND_WIDTH-1:0] ground_x_o, ground_y_o;

  pixel_to_ground_ipm_core DUT (.*);

  // shadow copy of the pose and intrinsics
  logic [ROT_ROW_W-1:0] rot_row [3];
  logic [TRN_VEC_W-1:0] trn_vec;
  logic [PP_W-1:0] pp_reg;
  logic [IFOC_W-1:0] ifoc_reg;

  pixel_t pending_px[$];
  result_t ground_exp[$];
  int errors = 0;
  int cycles = 0;

  bit req_taken, res_taken, nogap_tx, nogap_rx;
  int tx_gap = 0, rx_gap = 0, rx_hold = 0;
  bit hold_req = 0;

  initial begin
    clk_i = 0;
    forever #2 clk_i = ~clk_i;
  end

  function automatic longint rot_at(int k, int j);
    return longint'($signed(rot_row[k][16*j +: 16]));
  endfunction

  function automatic longint trn_at(int k);
    return longint'($signed(trn_vec[20*k +: 20]));
  endfunction

  function automatic logic signed [GROUND_WIDTH-1:0] axis_coord(int j, longint dir[3],
                                                                longint num, longint den);
    longint a, b;
    logic signed [127:0] prod, sq, t, r;
    logic [127:0] pm, dm, q;
    bit neg;
    a = 0;
    b = 0;
    for (int k = 0; k < 3; k++) begin
      a += rot_at(k, j) * dir[k];
      b += rot_at(k, j) * trn_at(k);
    end
    prod = 128'(signed'(num)) * 128'(signed'(a));
    neg  = ((num < 0) != (a < 0)) != (den < 0);
    pm   = prod < 0 ? -prod : prod;
    dm   = den < 0 ? 128'(-den) : 128'(den);
    // clamp the quotient magnitude at 2^62
    q    = (pm >= (dm << 62)) ? (128'd1 << 62) : pm / dm;
    sq   = neg ? -$signed(q) : $signed(q);
    t    = sq - 128'(signed'(b));
    r    = (t + 128'sd32768) >>> 16;
    if (r > 128'sd524287) r = 128'sd524287;
    if (r < -128'sd524288) r = -128'sd524288;
    return r[GROUND_WIDTH-1:0];
  endfunction

  function automatic result_t map_pixel(logic [PIX_W-1:0] u, logic [PIX_W-1:0] v);
    longint dir[3], den, num;
    result_t res;
    dir[0] = (longint'(u) - longint'(pp_reg[15:0])) * longint'(ifoc_reg[23:0]);
    dir[1] = (longint'(v) - longint'(pp_reg[31:16])) * longint'(ifoc_reg[47:24]);
    dir[2] = longint'(1) << DIR_FRAC;
    den = 0;
    num = 0;
    for (int k = 0; k < 3; k++) begin
      den += rot_at(k, 2) * dir[k];
      num += rot_at(k, 2) * trn_at(k);
    end
    res.x = '0;
    res.y = '0;
    if (den == 0) res.status = ST_PARALLEL;
    else if (num == 0 || ((num < 0) != (den < 0))) res.status = ST_BEHIND;
    else begin
      res.status = ST_HIT;
      res.x = axis_coord(0, dir, num, den);
      res.y = axis_coord(1, dir, num, den);
    end
    return res;
  endfunction

  // accept requests and results on the rising edge
  always @(posedge clk_i) begin
    result_t e;
    cycles++;
    if (cycles > CYCLE_LIMIT) begin
      $display("DONE: errors detected");
      $finish;
    end
    req_taken = rst_ni && push && !full;
    res_taken = rst_ni && pop && !empty;
    if (req_taken) ground_exp.push_back(map_pixel(pixel_u_i, pixel_v_i));
    if (res_taken) begin
      if (ground_exp.size() == 0) begin
        $error("unexpected result status=%0d x=%0d y=%0d", hit_status_o, ground_x_o,
               ground_y_o);
        errors++;
      end else begin
        e = ground_exp.pop_front();
        if (hit_status_o !== e.status) begin
          $error("hit_status expected %0d got %0d", e.status, hit_status_o);
          errors++;
        end
        if (ground_x_o !== e.x) begin
          $error("ground_x expected %0d got %0d", e.x, ground_x_o);
          errors++;
        end
        if (ground_y_o !== e.y) begin
          $error("ground_y expected %0d got %0d", e.y, ground_y_o);
          errors++;
        end
      end
    end
  end

  // sender: hold the request until taken, then idle a drawn number of cycles
  always @(negedge clk_i) begin
    pixel_t p;
    if (rst_ni && !(push && !req_taken)) begin
      if (push && req_taken) tx_gap = nogap_tx ? 0 : $urandom_range(0, 3);
      if (tx_gap > 0) begin
        tx_gap--;
        push <= 1'b0;
      end else if (pending_px.size() > 0) begin
        p = pending_px.pop_front();
        push <= 1'b1;
        pixel_u_i <= p.u;
        pixel_v_i <= p.v;
      end else begin
        push <= 1'b0;
      end
    end
  end

  // receiver: random pop gaps, plus one long hold-off on request
  always @(negedge clk_i) begin
    if (rst_ni) begin
      if (hold_req) begin
        hold_req = 0;
        rx_hold = 400;
      end
      if (res_taken) rx_gap = nogap_rx ? 0 : $urandom_range(0, 3);
      if (rx_hold > 0) begin
        rx_hold--;
        pop <= 1'b0;
      end else if (rx_gap > 0) begin
        rx_gap--;
        pop <= 1'b0;
      end else begin
        pop <= 1'b1;
      end
    end
  end

  task automatic reg_write(logic [CFG_IDX_W-1:0] idx, logic [CFG_W-1:0] data);
    @(negedge clk_i);
    cfg_we_i <= 1'b1;
    cfg_idx_i <= idx;
    cfg_data_i <= data;
    case (idx)
      REG_ROT0: rot_row[0] = data[ROT_ROW_W-1:0];
      REG_ROT1: rot_row[1] = data[ROT_ROW_W-1:0];
      REG_ROT2: rot_row[2] = data[ROT_ROW_W-1:0];
      REG_TRN:  trn_vec = data[TRN_VEC_W-1:0];
      REG_PP:   pp_reg = data[PP_W-1:0];
      REG_IFOC: ifoc_reg = data[IFOC_W-1:0];
      default: ;
    endcase
  endtask

  task automatic load_pose(logic [47:0] r0, logic [47:0] r1, logic [47:0] r2,
                           logic [59:0] t, logic [31:0] pp, logic [47:0] ifc);
    reg_write(REG_ROT0, CFG_W'(r0));
    reg_write(REG_ROT1, CFG_W'(r1));
    reg_write(REG_ROT2, CFG_W'(r2));
    reg_write(REG_TRN, t);
    reg_write(REG_PP, CFG_W'(pp));
    reg_write(REG_IFOC, CFG_W'(ifc));
    // spare indexes carry garbage that must be dropped
    reg_write(REG_SPARE6, CFG_W'({$urandom, $urandom}));
    reg_write(REG_SPARE7, CFG_W'({$urandom, $urandom}));
    @(negedge clk_i);
    cfg_we_i <= 1'b0;
  endtask

  task automatic drain();
    wait (pending_px.size() == 0 && !push && ground_exp.size() == 0);
    repeat (SETTLE) @(posedge clk_i);
  endtask

  function automatic logic [15:0] rand_coord(logic [15:0] c);
    case ($urandom_range(0, 4))
      0: return 16'($urandom);
      1: return c + 16'($urandom_range(0, 64)) - 16'd32;
      2: return $urandom_range(0, 1) ? 16'hFFFF : 16'h0000;
      default: return 16'($urandom_range(0, 640 * 16));
    endcase
  endfunction

  task automatic add_px(logic [15:0] u, logic [15:0] v);
    pixel_t p;
    p.u = u;
    p.v = v;
    pending_px.push_back(p);
  endtask

  task automatic add_random(int n);
    for (int i = 0; i < n; i++)
      add_px(rand_coord(pp_reg[15:0]), rand_coord(pp_reg[31:16]));
  endtask

  function automatic logic [15:0] unit_entry();
    case ($urandom_range(0, 3))
      0: return 16'h4000;
      1: return 16'hC000;
      2: return 16'($urandom_range(0, 16'h7FFF) - 16'h4000);
      default: return 16'($urandom);
    endcase
  endfunction

  function automatic logic [47:0] rand_row();
    return {unit_entry(), unit_entry(), unit_entry()};
  endfunction

  function automatic logic [59:0] rand_trn();
    logic [59:0] t;
    for (int k = 0; k < 3; k++)
      t[20*k +: 20] = $urandom_range(0, 1) ? 20'($urandom) : 20'($urandom_range(0, 65536));
    return t;
  endfunction

  function automatic logic [47:0] rand_ifoc();
    return {24'($urandom_range(1, 1 << 16)), 24'($urandom_range(1, 1 << 16))};
  endfunction

  initial begin
    rst_ni = 1'b0;
    push = 1'b0;
    pop = 1'b0;
    cfg_we_i = 1'b0;
    cfg_idx_i = REG_ROT0;
    cfg_data_i = '0;
    pixel_u_i = '0;
    pixel_v_i = '0;
    nogap_tx = 0;
    nogap_rx = 0;
    rot_row[0] = ROT0_RST;
    rot_row[1] = ROT1_RST;
    rot_row[2] = ROT2_RST;
    trn_vec = TRN_RST;
    pp_reg = PP_RST;
    ifoc_reg = IFOC_RST;
    repeat (6) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    // reset pose: zero translation, every ray lands behind the camera
    add_px(16'h0000, 16'h0000);
    add_px(16'hFFFF, 16'hFFFF);
    add_px(16'd5120, 16'd3840);
    add_random(20);
    drain();

    // camera two metres up looking down the rig z axis
    load_pose(ROT0_RST, ROT1_RST, ROT2_RST, {20'sd32768, 20'd0, 20'd0}, PP_RST, IFOC_RST);
    add_px(16'h0000, 16'hFFFF);
    add_px(16'hFFFF, 16'h0000);
    add_px(16'd5120, 16'd3840);
    add_random(40);
    drain();

    // optical axis lies in the ground plane: parallel rays
    load_pose(ROT0_RST, ROT1_RST, 48'd0, {20'sd32768, 20'sd100, 20'sd5}, PP_RST, IFOC_RST);
    add_px(16'h0000, 16'h0000);
    add_px(16'hFFFF, 16'hFFFF);
    add_random(10);
    drain();

    // register extremes, huge scales and saturation
    load_pose('1, '1, '1, '1, '1, '1);
    add_px(16'h0000, 16'h0000);
    add_px(16'hFFFF, 16'hFFFF);
    add_random(20);
    drain();
    load_pose(48'h8000_8000_8000, 48'h7FFF_7FFF_7FFF, 48'h8000_0001_7FFF,
              {20'h7FFFF, 20'h80000, 20'h7FFFF}, 32'hFFFF_0000, {24'hFFFFFF, 24'h000001});
    add_px(16'h0000, 16'hFFFF);
    add_px(16'hFFFF, 16'h0000);
    add_random(20);
    drain();

    // long receiver hold-off while the sender keeps offering
    load_pose(rand_row(), rand_row(), rand_row(), rand_trn(), 32'($urandom), rand_ifoc());
    nogap_tx = 1;
    hold_req = 1;
    add_random(120);
    drain();
    nogap_tx = 0;

    // random poses, with one back-to-back stretch on both sides
    for (int ph = 0; ph < 6; ph++) begin
      load_pose(rand_row(), rand_row(), rand_row(), rand_trn(),
                {16'($urandom_range(0, 480 * 16)), 16'($urandom_range(0, 640 * 16))},
                rand_ifoc());
      nogap_tx = (ph == 2);
      nogap_rx = (ph == 2);
      add_random(100);
      drain();
    end

    if (errors == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end
endmodule
